// File: rtl/rti_pkg.sv
// shared constants and register codes for the ray/triangle intersection block
// no dependencies
package rti_pkg;

  localparam int COORD_BITS_DEF = 21;
  localparam int FRAC_BITS_DEF  = 12;
  localparam int WORK_BITS      = 56;
  localparam int CFG_BITS       = 63;
  localparam int CFG_IDX_BITS   = 3;
  localparam int EPS_BITS       = 16;
  localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_VERTEX0 = 3'd0,
    REG_EDGE1   = 3'd1,
    REG_EDGE2   = 3'd2,
    REG_NORMAL0 = 3'd3,
    REG_NORMAL1 = 3'd4,
    REG_NORMAL2 = 3'd5,
    REG_EPSILON = 3'd6
  } cfg_idx_e;

endpackage

// File: rtl/rti_ray_if.sv
// ray input channel: valid/ready handshake with ray origin, direction and flag
// depends on rti_pkg
interface rti_ray_if import rti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic signed [COORD_BITS-1:0] origin_z;
  logic signed [COORD_BITS-1:0] dir_x;
  logic signed [COORD_BITS-1:0] dir_y;
  logic signed [COORD_BITS-1:0] dir_z;
  logic                         is_refracted;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, is_refracted,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, is_refracted,
    output ready
  );
endinterface

// File: rtl/rti_hit_if.sv
// hit result channel: valid/ready handshake with hit point, normal and distance
// depends on rti_pkg
interface rti_hit_if import rti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic signed [COORD_BITS-1:0] shade_normal_x;
  logic signed [COORD_BITS-1:0] shade_normal_y;
  logic signed [COORD_BITS-1:0] shade_normal_z;
  logic        [COORD_BITS-2:0] distance;

  modport source (
    output valid, hit, point_x, point_y, point_z,
           shade_normal_x, shade_normal_y, shade_normal_z, distance,
    input  ready
  );
  modport sink (
    input  valid, hit, point_x, point_y, point_z,
           shade_normal_x, shade_normal_y, shade_normal_z, distance,
    output ready
  );
endinterface

// File: rtl/ray_triangle_intersect.sv
// ray/triangle intersection (moller-trumbore) in signed fixed point, top level
// depends on rti_pkg, rti_ray_if, rti_hit_if and rti_div
//
// one ray word is taken every cycle unless the output stalls, and one result word
// leaves per ray, in order. the default format is Q9.12 in 21 bits. the pipeline is
// five stages of cross and dot products, then the three fraction dividers for t, u
// and v, which resolve one quotient bit per stage (COORD_BITS + FRAC_BITS + 1 stages),
// then one stage of products and one output register. the whole pipeline holds
// while the output word waits and ready is low; ready to the ray side is high
// whenever the output register is empty or being taken. the triangle (vertex,
// edges, vertex normals) and epsilon are written through the register port and
// must be stable while rays are in flight. a miss gives hit=0 with all other
// fields zero; t is clamped inside the divider, which does not change any result.
module ray_triangle_intersect import rti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  rti_ray_if.sink                 ray_i,
  rti_hit_if.source               hit_o
);
  localparam int CB = COORD_BITS;
  localparam int FB = FRAC_BITS;
  localparam int WB = WORK_BITS;
  localparam int XB = 2 * WB;
  localparam int PACK_W = 3 * CB;
  // widths of the truncated products and sums, clipped at the working width
  localparam int SW  = CB + 1;
  localparam int TP  = (2*CB - FB < WB) ? 2*CB - FB : WB;
  localparam int PW  = (TP + 1 < WB) ? TP + 1 : WB;
  localparam int TQ  = (SW + CB - FB < WB) ? SW + CB - FB : WB;
  localparam int QW  = (TQ + 1 < WB) ? TQ + 1 : WB;
  localparam int TD  = (CB + PW - FB < WB) ? CB + PW - FB : WB;
  localparam int DW  = (TD + 2 < WB) ? TD + 2 : WB;
  localparam int TU  = (SW + PW - FB < WB) ? SW + PW - FB : WB;
  localparam int NUW = (TU + 2 < WB) ? TU + 2 : WB;
  localparam int TV  = (CB + QW - FB < WB) ? CB + QW - FB : WB;
  localparam int NVW = (TV + 2 < WB) ? TV + 2 : WB;
  localparam int NW0 = (DW > NUW) ? DW : NUW;
  localparam int NW  = ((NW0 > NVW) ? NW0 : NVW) + 1;
  localparam int NUN = NW - 1;
  localparam int QB  = CB + FB + 1;
  localparam int MG  = QB + 1 + CB;
  localparam int TT  = (MG - FB < WB) ? MG - FB : WB;
  localparam int MN  = FB + 2 + CB;
  localparam int TN  = (MN - FB < WB) ? MN - FB : WB;
  localparam int EB  = (QB > EPS_BITS) ? QB : EPS_BITS;

  typedef logic signed [CB-1:0] crd_t;
  typedef logic signed [WB-1:0] wk_t;
  typedef logic signed [XB-1:0] xw_t;
  typedef struct packed {
    logic                 ok;
    logic [2:0][CB-1:0]   o;
    logic [2:0][CB-1:0]   d;
  } sb_t;

  // saturate to the working width
  function automatic wk_t sat_w(input xw_t x);
    xw_t hi;
    xw_t lo;
    hi = (xw_t'(1) <<< (WB - 1)) - xw_t'(1);
    lo = -(xw_t'(1) <<< (WB - 1));
    if (x > hi) return wk_t'(hi);
    if (x < lo) return wk_t'(lo);
    return wk_t'(x);
  endfunction

  // saturate to the coordinate width
  function automatic crd_t sat_c(input xw_t x);
    xw_t hi;
    xw_t lo;
    hi = (xw_t'(1) <<< (CB - 1)) - xw_t'(1);
    lo = -(xw_t'(1) <<< (CB - 1));
    if (x > hi) return crd_t'(hi);
    if (x < lo) return crd_t'(lo);
    return crd_t'(x);
  endfunction

  // full product shifted down by the fraction bits, rounding toward zero
  function automatic wk_t mq(input xw_t p);
    xw_t bias;
    bias = (p < 0) ? ((xw_t'(1) <<< FB) - xw_t'(1)) : xw_t'(0);
    return sat_w((p + bias) >>> FB);
  endfunction

  // packed component k, bits above the register read as zero
  function automatic crd_t comp(input logic [CFG_BITS-1:0] r, input int k);
    logic [CFG_BITS+PACK_W-1:0] ext;
    ext = {{PACK_W{1'b0}}, r};
    return crd_t'(ext[k*CB +: CB]);
  endfunction

  function automatic int nxt(input int k);
    return (k == 2) ? 0 : k + 1;
  endfunction

  function automatic int prv(input int k);
    return (k == 0) ? 2 : k - 1;
  endfunction

  // ---------------------------------------------------------------------------
  // triangle registers
  // ---------------------------------------------------------------------------
  logic [CFG_BITS-1:0] v0_q, e1_q, e2_q, n0_q, n1_q, n2_q;
  logic [EPS_BITS-1:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= '0;
      e1_q  <= '0;
      e2_q  <= '0;
      n0_q  <= '0;
      n1_q  <= '0;
      n2_q  <= '0;
      eps_q <= EPS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_VERTEX0: v0_q  <= cfg_data_i;
        REG_EDGE1:   e1_q  <= cfg_data_i;
        REG_EDGE2:   e2_q  <= cfg_data_i;
        REG_NORMAL0: n0_q  <= cfg_data_i;
        REG_NORMAL1: n1_q  <= cfg_data_i;
        REG_NORMAL2: n2_q  <= cfg_data_i;
        REG_EPSILON: eps_q <= cfg_data_i[EPS_BITS-1:0];
        default: ;
      endcase
    end
  end

  crd_t v0 [3], e1 [3], e2 [3], n0 [3], n1 [3], n2 [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v0[k] = comp(v0_q, k);
      e1[k] = comp(e1_q, k);
      e2[k] = comp(e2_q, k);
      n0[k] = comp(n0_q, k);
      n1[k] = comp(n1_q, k);
      n2[k] = comp(n2_q, k);
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: the whole pipeline moves unless the output word is stuck
  // ---------------------------------------------------------------------------
  logic en;
  logic h_vld_q;
  assign en          = !h_vld_q || hit_o.ready;
  assign ray_i.ready = en;

  crd_t ro [3], rd [3];
  assign ro[0] = ray_i.origin_x;
  assign ro[1] = ray_i.origin_y;
  assign ro[2] = ray_i.origin_z;
  assign rd[0] = ray_i.dir_x;
  assign rd[1] = ray_i.dir_y;
  assign rd[2] = ray_i.dir_z;

  // stage a: s = origin - vertex0, products of dir x edge2
  logic                 a_vld_q, a_refr_q;
  crd_t                 a_o_q [3], a_d_q [3];
  logic signed [SW-1:0] a_s_q [3];
  logic signed [TP-1:0] a_pp_q [3][2];
  logic signed [TP-1:0] a_pp_d [3][2];
  logic signed [SW-1:0] a_s_d [3];
  logic signed [2*CB-1:0] pa0 [3], pa1 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa0[k] = rd[nxt(k)] * e2[prv(k)];
      pa1[k] = rd[prv(k)] * e2[nxt(k)];
      a_pp_d[k][0] = TP'(mq(xw_t'(pa0[k])));
      a_pp_d[k][1] = TP'(mq(xw_t'(pa1[k])));
      a_s_d[k] = SW'(ro[k]) - SW'(v0[k]);
    end
  end

  // stage b: p = dir x edge2, products of s x edge1
  logic                 b_vld_q, b_refr_q;
  crd_t                 b_o_q [3], b_d_q [3];
  logic signed [SW-1:0] b_s_q [3];
  logic signed [PW-1:0] b_p_q [3], b_p_d [3];
  logic signed [TQ-1:0] b_qp_q [3][2], b_qp_d [3][2];
  logic signed [SW+CB-1:0] pb0 [3], pb1 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      b_p_d[k] = PW'(sat_w(xw_t'(a_pp_q[k][0]) - xw_t'(a_pp_q[k][1])));
      pb0[k] = a_s_q[nxt(k)] * e1[prv(k)];
      pb1[k] = a_s_q[prv(k)] * e1[nxt(k)];
      b_qp_d[k][0] = TQ'(mq(xw_t'(pb0[k])));
      b_qp_d[k][1] = TQ'(mq(xw_t'(pb1[k])));
    end
  end

  // stage c: q = s x edge1, terms of det = edge1 . p and nu = s . p
  logic                 c_vld_q, c_refr_q;
  crd_t                 c_o_q [3], c_d_q [3];
  logic signed [QW-1:0] c_q_q [3], c_q_d [3];
  logic signed [TD-1:0] c_dt_q [3], c_dt_d [3];
  logic signed [TU-1:0] c_ut_q [3], c_ut_d [3];
  logic signed [CB+PW-1:0] pcd [3];
  logic signed [SW+PW-1:0] pcu [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_q_d[k] = QW'(sat_w(xw_t'(b_qp_q[k][0]) - xw_t'(b_qp_q[k][1])));
      pcd[k] = e1[k] * b_p_q[k];
      pcu[k] = b_s_q[k] * b_p_q[k];
      c_dt_d[k] = TD'(mq(xw_t'(pcd[k])));
      c_ut_d[k] = TU'(mq(xw_t'(pcu[k])));
    end
  end

  // stage d: det and nu sums, terms of nv = dir . q and nt = edge2 . q
  logic                  d_vld_q, d_refr_q;
  crd_t                  d_o_q [3], d_d_q [3];
  logic signed [DW-1:0]  d_det_q, d_det_d;
  logic signed [NUW-1:0] d_nu_q, d_nu_d;
  logic signed [TV-1:0]  d_vt_q [3], d_vt_d [3];
  logic signed [TV-1:0]  d_tt_q [3], d_tt_d [3];
  logic signed [CB+QW-1:0] pdv [3], pdt [3];

  always_comb begin
    d_det_d = DW'(sat_w(xw_t'(c_dt_q[0]) + xw_t'(c_dt_q[1]) + xw_t'(c_dt_q[2])));
    d_nu_d  = NUW'(sat_w(xw_t'(c_ut_q[0]) + xw_t'(c_ut_q[1]) + xw_t'(c_ut_q[2])));
    for (int k = 0; k < 3; k++) begin
      pdv[k] = c_d_q[k] * c_q_q[k];
      pdt[k] = e2[k] * c_q_q[k];
      d_vt_d[k] = TV'(mq(xw_t'(pdv[k])));
      d_tt_d[k] = TV'(mq(xw_t'(pdt[k])));
    end
  end

  // stage e: nv and nt sums, sign flip for rays inside the object
  logic                 e_vld_q;
  crd_t                 e_o_q [3], e_d_q [3];
  logic signed [NW-1:0] e_det_q, e_nu_q, e_nv_q, e_nt_q;
  logic signed [NW-1:0] e_det_d, e_nu_d, e_nv_d, e_nt_d;
  logic signed [NW-1:0] nv_s, nt_s;

  always_comb begin
    nv_s = NW'(sat_w(xw_t'(d_vt_q[0]) + xw_t'(d_vt_q[1]) + xw_t'(d_vt_q[2])));
    nt_s = NW'(sat_w(xw_t'(d_tt_q[0]) + xw_t'(d_tt_q[1]) + xw_t'(d_tt_q[2])));
    if (d_refr_q) begin
      e_det_d = -NW'(d_det_q);
      e_nu_d  = -NW'(d_nu_q);
      e_nv_d  = -nv_s;
      e_nt_d  = -nt_s;
    end else begin
      e_det_d = NW'(d_det_q);
      e_nu_d  = NW'(d_nu_q);
      e_nv_d  = nv_s;
      e_nt_d  = nt_s;
    end
  end

  // face, determinant and barycentric range tests alongside the first divider stage
  logic signed [NW:0]       nuv;
  logic signed [EPS_BITS:0] eps_s;
  logic                     tri_ok;

  always_comb begin
    eps_s  = $signed({1'b0, eps_q});
    nuv    = (NW+1)'(e_nu_q) + (NW+1)'(e_nv_q);
    tri_ok = !(e_det_q < eps_s || e_det_q <= 0)
          && !(e_nu_q < 0 || e_nu_q > e_det_q)
          && !(e_nv_q < 0 || nuv > (NW+1)'(e_det_q))
          && !(e_nt_q < 0);
  end

  // dividers for t, u and v with the ray riding alongside
  logic [QB-1:0] t_quo, u_quo, v_quo;

  rti_div #(.NB(NUN), .FB(FB), .QB(QB)) u_div_t (
    .clk_i (clk_i), .en_i (en),
    .num_i (e_nt_q[NUN-1:0]), .den_i (e_det_q[NUN-1:0]), .quo_o (t_quo)
  );
  rti_div #(.NB(NUN), .FB(FB), .QB(QB)) u_div_u (
    .clk_i (clk_i), .en_i (en),
    .num_i (e_nu_q[NUN-1:0]), .den_i (e_det_q[NUN-1:0]), .quo_o (u_quo)
  );
  rti_div #(.NB(NUN), .FB(FB), .QB(QB)) u_div_v (
    .clk_i (clk_i), .en_i (en),
    .num_i (e_nv_q[NUN-1:0]), .den_i (e_det_q[NUN-1:0]), .quo_o (v_quo)
  );

  logic dv_vld_q [QB];
  sb_t  sb_q [QB];
  sb_t  sb_in;

  always_comb begin
    sb_in.ok = tri_ok;
    for (int k = 0; k < 3; k++) begin
      sb_in.o[k] = e_o_q[k];
      sb_in.d[k] = e_d_q[k];
    end
  end

  // stage g: distance test, t * dir and barycentric weights times normals
  logic                    g_vld_q, g_hit_q;
  crd_t                    g_o_q [3];
  logic [QB-1:0]           g_t_q;
  logic signed [TT-1:0]    g_tp_q [3], g_tp_d [3];
  logic signed [TN-1:0]    g_nt_q [3][3], g_nt_d [3][3];
  logic signed [QB:0]      g_ts;
  logic signed [FB+1:0]    g_us, g_vs, g_ws;
  logic signed [MG-1:0]    pgt [3];
  logic signed [MN-1:0]    pgw [3], pgu [3], pgv [3];
  logic                    g_hit_d;
  crd_t                    sb_d [3];

  always_comb begin
    g_ts    = $signed({1'b0, t_quo});
    g_us    = $signed({1'b0, u_quo[FB:0]});
    g_vs    = $signed({1'b0, v_quo[FB:0]});
    g_ws    = $signed((FB+2)'(1) << FB) - g_us - g_vs;
    g_hit_d = sb_q[QB-1].ok && (EB'(t_quo) >= EB'(eps_q));
    for (int k = 0; k < 3; k++) begin
      sb_d[k]     = $signed(sb_q[QB-1].d[k]);
      pgt[k]      = g_ts * sb_d[k];
      g_tp_d[k]   = TT'(mq(xw_t'(pgt[k])));
      pgw[k]      = g_ws * n0[k];
      pgu[k]      = g_us * n1[k];
      pgv[k]      = g_vs * n2[k];
      g_nt_d[k][0] = TN'(mq(xw_t'(pgw[k])));
      g_nt_d[k][1] = TN'(mq(xw_t'(pgu[k])));
      g_nt_d[k][2] = TN'(mq(xw_t'(pgv[k])));
    end
  end

  // stage h: output register, everything zero on a miss
  logic            h_hit_q;
  crd_t            h_pt_q [3], h_nm_q [3];
  logic [CB-2:0]   h_dist_q;
  crd_t            h_pt_d [3], h_nm_d [3];
  logic [CB-2:0]   h_dist_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      h_pt_d[k] = '0;
      h_nm_d[k] = '0;
      if (g_hit_q) begin
        h_pt_d[k] = sat_c(xw_t'(g_o_q[k]) + xw_t'(g_tp_q[k]));
        h_nm_d[k] = sat_c(xw_t'(g_nt_q[k][0]) + xw_t'(g_nt_q[k][1])
                          + xw_t'(g_nt_q[k][2]));
      end
    end
    h_dist_d = '0;
    if (g_hit_q) begin
      h_dist_d = (|g_t_q[QB-1:CB-1]) ? '1 : g_t_q[CB-2:0];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      for (int k = 0; k < QB; k++) dv_vld_q[k] <= 1'b0;
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= ray_i.valid;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
      dv_vld_q[0] <= e_vld_q;
      for (int k = 1; k < QB; k++) dv_vld_q[k] <= dv_vld_q[k-1];
      g_vld_q <= dv_vld_q[QB-1];
      h_vld_q <= g_vld_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_refr_q <= ray_i.is_refracted;
      b_refr_q <= a_refr_q;
      c_refr_q <= b_refr_q;
      d_refr_q <= c_refr_q;
      for (int k = 0; k < 3; k++) begin
        a_o_q[k]  <= ro[k];
        a_d_q[k]  <= rd[k];
        a_s_q[k]  <= a_s_d[k];
        a_pp_q[k] <= a_pp_d[k];
        b_o_q[k]  <= a_o_q[k];
        b_d_q[k]  <= a_d_q[k];
        b_s_q[k]  <= a_s_q[k];
        b_p_q[k]  <= b_p_d[k];
        b_qp_q[k] <= b_qp_d[k];
        c_o_q[k]  <= b_o_q[k];
        c_d_q[k]  <= b_d_q[k];
        c_q_q[k]  <= c_q_d[k];
        c_dt_q[k] <= c_dt_d[k];
        c_ut_q[k] <= c_ut_d[k];
        d_o_q[k]  <= c_o_q[k];
        d_d_q[k]  <= c_d_q[k];
        d_vt_q[k] <= d_vt_d[k];
        d_tt_q[k] <= d_tt_d[k];
        e_o_q[k]  <= d_o_q[k];
        e_d_q[k]  <= d_d_q[k];
        g_o_q[k]  <= $signed(sb_q[QB-1].o[k]);
        g_tp_q[k] <= g_tp_d[k];
        g_nt_q[k] <= g_nt_d[k];
        h_pt_q[k] <= h_pt_d[k];
        h_nm_q[k] <= h_nm_d[k];
      end
      d_det_q <= d_det_d;
      d_nu_q  <= d_nu_d;
      e_det_q <= e_det_d;
      e_nu_q  <= e_nu_d;
      e_nv_q  <= e_nv_d;
      e_nt_q  <= e_nt_d;
      sb_q[0] <= sb_in;
      for (int k = 1; k < QB; k++) sb_q[k] <= sb_q[k-1];
      g_hit_q  <= g_hit_d;
      g_t_q    <= t_quo;
      h_hit_q  <= g_hit_q;
      h_dist_q <= h_dist_d;
    end
  end

  assign hit_o.valid          = h_vld_q;
  assign hit_o.hit            = h_hit_q;
  assign hit_o.point_x        = h_pt_q[0];
  assign hit_o.point_y        = h_pt_q[1];
  assign hit_o.point_z        = h_pt_q[2];
  assign hit_o.shade_normal_x = h_nm_q[0];
  assign hit_o.shade_normal_y = h_nm_q[1];
  assign hit_o.shade_normal_z = h_nm_q[2];
  assign hit_o.distance       = h_dist_q;

  // a miss word carries nothing but zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o.valid && !hit_o.hit |-> hit_o.point_x == 0 && hit_o.point_y == 0
      && hit_o.point_z == 0 && hit_o.shade_normal_x == 0 && hit_o.shade_normal_y == 0
      && hit_o.shade_normal_z == 0 && hit_o.distance == 0)
    else $error("miss word with non-zero fields");

  // a hit never lies nearer than epsilon
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o.valid && hit_o.hit |-> EB'(hit_o.distance) >= EB'(eps_q))
    else $error("hit closer than epsilon");

  // barycentrics of a ray that passed the range tests stay inside the triangle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld_q[QB-1] && sb_q[QB-1].ok
      |-> ((QB+1)'(u_quo) + (QB+1)'(v_quo)) <= ((QB+1)'(1) << FB))
    else $error("u + v beyond one for an accepted ray");

  // a stalled pipeline keeps its words in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(g_vld_q) && $stable(dv_vld_q[QB-1]) && $stable(h_hit_q))
    else $error("pipeline moved during a stall");

endmodule

// File: rtl/rti_div.sv
// pipelined restoring divider: floor(num * 2^FB / den), one quotient bit per stage
// saturates to all ones when the quotient needs more than QB bits; no dependencies
module rti_div #(
  parameter int NB = 43,
  parameter int FB = 12,
  parameter int QB = 34
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NB-1:0] num_i,
  input  logic [NB-1:0] den_i,
  output logic [QB-1:0] quo_o
);
  localparam int RW = NB + FB;
  localparam int CW = NB + QB + 1;

  logic [RW-1:0] rem_q [QB];
  logic [RW-1:0] rem_d [QB];
  logic [NB-1:0] den_q [QB];
  logic [NB-1:0] den_d [QB];
  logic [QB-1:0] quo_q [QB];
  logic [QB-1:0] quo_d [QB];
  logic          ovf_q [QB];
  logic          ovf_d [QB];
  logic [CW-1:0] rem_w [QB];
  logic [CW-1:0] dsh_w [QB];

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      if (k == 0) begin
        rem_w[k] = CW'({num_i, {FB{1'b0}}});
        den_d[k] = den_i;
        quo_d[k] = '0;
        ovf_d[k] = (CW'(num_i) >= (CW'(den_i) << (QB - FB)));
      end else begin
        rem_w[k] = CW'(rem_q[k-1]);
        den_d[k] = den_q[k-1];
        quo_d[k] = quo_q[k-1];
        ovf_d[k] = ovf_q[k-1];
      end
      // bit QB-1-k of the quotient
      dsh_w[k] = CW'(den_d[k]) << (QB - 1 - k);
      if (rem_w[k] >= dsh_w[k]) begin
        rem_d[k] = RW'(rem_w[k] - dsh_w[k]);
        quo_d[k][QB-1-k] = 1'b1;
      end else begin
        rem_d[k] = RW'(rem_w[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QB; k++) begin
        rem_q[k] <= rem_d[k];
        den_q[k] <= den_d[k];
        quo_q[k] <= quo_d[k];
        ovf_q[k] <= ovf_d[k];
      end
    end
  end

  assign quo_o = ovf_q[QB-1] ? '1 : quo_q[QB-1];

endmodule
